@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/i2cm_pkg.sv @@
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C memory transaction master.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	localparam int LEN_W = 16;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_SUPPLY = 2'd3;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ABORT = 2'd2;

	localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
	localparam logic [1:0] CFG_WIDE     = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

	localparam logic [6:0]  DEV_ADDR_RST = 7'd80;
	localparam logic        WIDE_RST     = 1'b1;
	localparam logic [17:0] TIMEOUT_RST  = 18'd156000;

	typedef struct packed {
		logic             we;
		logic [1:0]       index;
		logic [17:0]      data;
	} cfg_wr_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [15:0]      mem_address;
		logic [LEN_W-1:0] length;
		logic [7:0]       data_byte;
		logic             sda_in;
	} item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             busy_res;
		logic             read_valid;
		logic [7:0]       read_byte;
		logic             need_data;
		logic             sda_level;
		logic             scl_level;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/i2cm_in_reg.sv @@
// ---------------------------------------------------------------------------
// i2cm_in_reg
// Input register stage: holds one item until the engine takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_in_reg (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  i2cm_pkg::item_t  in_item,
	input  wire              can_load,
	output i2cm_pkg::item_t  item_s1,
	output logic             go
);
	import i2cm_pkg::*;

	logic v_s1;

	assign go       = v_s1 && can_load;
	assign in_ready = !v_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ rtl/i2cm_engine.sv @@
// ---------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one bus step per tick, begin and supply commands, config.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2cm_engine (
	input  wire               clk,
	input  wire               arst_n,
	input  i2cm_pkg::cfg_wr_t cfg,
	input  wire               go,
	input  i2cm_pkg::item_t   item_s1,
	output i2cm_pkg::res_t    res
);
	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		P_IDLE, P_START1, P_DEV_W, P_ADDR_HI, P_ADDR_LO, P_WAIT,
		P_DATA, P_START2, P_DEV_R, P_RECV, P_STOP
	} phase_t;

	logic [6:0]       dev_addr_q;
	logic             wide_q;
	logic [17:0]      timeout_q;

	phase_t           phase_q, n_phase;
	logic [1:0]       step_q, n_step;
	logic [3:0]       bit_q, n_bit;
	logic [7:0]       shift_q, n_shift;
	logic [LEN_W-1:0] bcnt_q, n_bcnt;
	logic [LEN_W-1:0] xlen_q, n_xlen;
	logic [15:0]      addr_q, n_addr;
	logic             is_read_q, n_is_read;
	logic [17:0]      wait_q, n_wait;
	logic             rdy_q, n_rdy;
	logic             scl_q, n_scl;
	logic             sda_q, n_sda;

	logic [7:0]       r_byte;
	logic             r_valid;
	logic [1:0]       r_status;
	logic [17:0]      limit;
	logic [17:0]      wait_inc;
	logic [LEN_W-1:0] bcnt_inc;
	logic [7:0]       recv_sh;

	assign limit    = (timeout_q == 18'd0) ? 18'd1 : timeout_q;
	assign wait_inc = wait_q + 18'd1;
	assign bcnt_inc = bcnt_q + LEN_W'(1);
	assign recv_sh  = {shift_q[6:0], item_s1.sda_in};

	always_comb begin
		n_phase   = phase_q;
		n_step    = step_q;
		n_bit     = bit_q;
		n_shift   = shift_q;
		n_bcnt    = bcnt_q;
		n_xlen    = xlen_q;
		n_addr    = addr_q;
		n_is_read = is_read_q;
		n_wait    = wait_q;
		n_rdy     = rdy_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		r_byte    = 8'd0;
		r_valid   = 1'b0;
		r_status  = ST_NONE;
		case (item_s1.cmd)
			CMD_TICK: begin
				case (phase_q)
					P_START1, P_START2: begin
						if (step_q == 2'd0) begin
							n_sda  = 1'b1;
							n_step = 2'd1;
						end else if (step_q == 2'd1) begin
							n_scl  = 1'b1;
							n_step = 2'd2;
						end else if (step_q == 2'd2) begin
							n_sda  = 1'b0;
							n_step = 2'd3;
						end else begin
							n_scl  = 1'b0;
							n_bit  = 4'd0;
							n_step = 2'd0;
							if (phase_q == P_START1) begin
								n_phase = P_DEV_W;
								n_shift = {dev_addr_q, 1'b0};
							end else begin
								n_phase = P_DEV_R;
								n_shift = {dev_addr_q, 1'b1};
							end
						end
					end
					P_DEV_W, P_ADDR_HI, P_ADDR_LO, P_DATA, P_DEV_R: begin
						if (!bit_q[3]) begin
							if (step_q == 2'd0) begin
								n_sda  = shift_q[7];
								n_step = 2'd1;
							end else if (step_q == 2'd1) begin
								n_scl  = 1'b1;
								n_step = 2'd2;
							end else begin
								n_scl   = 1'b0;
								n_shift = {shift_q[6:0], 1'b0};
								n_bit   = bit_q + 4'd1;
								n_step  = 2'd0;
							end
						end else if (step_q == 2'd0) begin
							n_sda  = 1'b1;
							n_step = 2'd1;
						end else if (step_q == 2'd1) begin
							n_scl  = 1'b1;
							n_wait = 18'd0;
							n_step = 2'd2;
						end else if (!item_s1.sda_in) begin
							// ACK seen: drive the clock low and pick the next phase
							n_scl = 1'b0;
							case (phase_q)
								P_DEV_W: begin
									n_bit   = 4'd0;
									n_step  = 2'd0;
									if (wide_q) begin
										n_phase = P_ADDR_HI;
										n_shift = addr_q[15:8];
									end else begin
										n_phase = P_ADDR_LO;
										n_shift = addr_q[7:0];
									end
								end
								P_ADDR_HI: begin
									n_phase = P_ADDR_LO;
									n_shift = addr_q[7:0];
									n_bit   = 4'd0;
									n_step  = 2'd0;
								end
								P_ADDR_LO: begin
									if (is_read_q) begin
										n_phase = P_START2;
										n_step  = 2'd0;
									end else if (xlen_q == '0) begin
										n_phase = P_STOP;
										n_step  = 2'd0;
									end else begin
										n_phase = P_WAIT;
										n_rdy   = 1'b0;
									end
								end
								P_DATA: begin
									n_bcnt = bcnt_inc;
									if (bcnt_inc == xlen_q) begin
										n_phase = P_STOP;
										n_step  = 2'd0;
									end else begin
										n_phase = P_WAIT;
										n_rdy   = 1'b0;
									end
								end
								default: begin
									if (xlen_q == '0) begin
										n_phase = P_STOP;
										n_step  = 2'd0;
									end else begin
										n_phase = P_RECV;
										n_bit   = 4'd0;
										n_step  = 2'd0;
										n_shift = 8'd0;
									end
								end
							endcase
						end else begin
							n_wait = wait_inc;
							if (wait_inc >= limit) begin
								// no ACK in time: drop the transaction
								n_scl    = 1'b1;
								n_sda    = 1'b1;
								n_phase  = P_IDLE;
								n_step   = 2'd0;
								n_bit    = 4'd0;
								n_rdy    = 1'b0;
								r_status = ST_ABORT;
							end
						end
					end
					P_WAIT: begin
						if (rdy_q) begin
							n_rdy   = 1'b0;
							n_phase = P_DATA;
							n_bit   = 4'd0;
							n_step  = 2'd0;
						end
					end
					P_RECV: begin
						if (!bit_q[3]) begin
							if (step_q == 2'd0) begin
								n_sda  = 1'b1;
								n_step = 2'd1;
							end else if (step_q == 2'd1) begin
								n_scl  = 1'b1;
								n_step = 2'd2;
							end else begin
								n_shift = recv_sh;
								n_scl   = 1'b0;
								n_bit   = bit_q + 4'd1;
								n_step  = 2'd0;
								if (bit_q == 4'd7) begin
									r_byte  = recv_sh;
									r_valid = 1'b1;
								end
							end
						end else if (step_q == 2'd0) begin
							// NACK the last byte, ACK the others
							n_sda  = (bcnt_inc == xlen_q);
							n_step = 2'd1;
						end else if (step_q == 2'd1) begin
							n_scl  = 1'b1;
							n_step = 2'd2;
						end else begin
							n_scl  = 1'b0;
							n_bcnt = bcnt_inc;
							if (bcnt_inc == xlen_q) begin
								n_phase = P_STOP;
								n_step  = 2'd0;
							end else begin
								n_bit   = 4'd0;
								n_step  = 2'd0;
								n_shift = 8'd0;
							end
						end
					end
					P_STOP: begin
						if (step_q == 2'd0) begin
							n_sda  = 1'b0;
							n_step = 2'd1;
						end else if (step_q == 2'd1) begin
							n_scl  = 1'b1;
							n_step = 2'd2;
						end else begin
							n_sda    = 1'b1;
							n_phase  = P_IDLE;
							n_step   = 2'd0;
							n_bit    = 4'd0;
							r_status = ST_DONE;
						end
					end
					default: begin
						n_phase = P_IDLE;
						n_scl   = 1'b1;
						n_sda   = 1'b1;
					end
				endcase
			end
			CMD_SUPPLY: begin
				if (phase_q == P_WAIT && !rdy_q) begin
					n_shift = item_s1.data_byte;
					n_rdy   = 1'b1;
				end
			end
			default: begin
				if (phase_q == P_IDLE) begin
					n_addr    = item_s1.mem_address;
					n_xlen    = item_s1.length;
					n_is_read = (item_s1.cmd == CMD_READ);
					n_bcnt    = '0;
					n_bit     = 4'd0;
					n_step    = 2'd0;
					n_wait    = 18'd0;
					n_rdy     = 1'b0;
					n_shift   = 8'd0;
					n_phase   = P_START1;
				end
			end
		endcase

		res.scl_level  = n_scl;
		res.sda_level  = n_sda;
		res.need_data  = (n_phase == P_WAIT) && !n_rdy;
		res.read_byte  = r_byte;
		res.read_valid = r_valid;
		res.busy_res   = (n_phase != P_IDLE);
		res.status     = r_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			wide_q     <= WIDE_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				CFG_DEV_ADDR: dev_addr_q <= cfg.data[6:0];
				CFG_WIDE:     wide_q     <= cfg.data[0];
				CFG_TIMEOUT:  timeout_q  <= cfg.data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= P_IDLE;
			step_q    <= 2'd0;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			bcnt_q    <= '0;
			xlen_q    <= '0;
			addr_q    <= 16'd0;
			is_read_q <= 1'b0;
			wait_q    <= 18'd0;
			rdy_q     <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
		end else if (go) begin
			phase_q   <= n_phase;
			step_q    <= n_step;
			bit_q     <= n_bit;
			shift_q   <= n_shift;
			bcnt_q    <= n_bcnt;
			xlen_q    <= n_xlen;
			addr_q    <= n_addr;
			is_read_q <= n_is_read;
			wait_q    <= n_wait;
			rdy_q     <= n_rdy;
			scl_q     <= n_scl;
			sda_q     <= n_sda;
		end
	end

	`ASSERT_IMPL(a_status_idle, clk, arst_n, go && res.status != ST_NONE, !res.busy_res)
	`ASSERT_IMPL(a_rvalid_recv, clk, arst_n, go && res.read_valid, phase_q == P_RECV)
	`ASSERT_NEXT(a_abort_release, clk, arst_n, go && res.status == ST_ABORT,
		phase_q == P_IDLE && scl_q && sda_q)

endmodule

`default_nettype wire

@@ rtl/i2cm_out_reg.sv @@
// ---------------------------------------------------------------------------
// i2cm_out_reg
// Result register: holds one result until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_out_reg (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             go,
	input  i2cm_pkg::res_t  res,
	output logic            can_load,
	output logic            out_valid,
	input  wire             out_ready,
	output i2cm_pkg::res_t  res_q
);
	import i2cm_pkg::*;

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ rtl/i2c_memory_transaction_master_top.sv @@
// ---------------------------------------------------------------------------
// i2c_memory_transaction_master_top
// Bit-level I2C master for memory devices, one bus level change per tick.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries commands: s_tuser is the command (tick, begin
//   write, begin read, supply byte), s_tdata the address, length, write byte
//   and the sampled SDA level. Every command yields exactly one result on the
//   master stream m_*: the SCL/SDA drive levels, need_data, the received byte
//   with its valid flag, busy and a status code (done or ACK timeout).
//   The cfg_* port sets the device address, one or two address bytes and the
//   ACK timeout; write it only while no transaction runs.
// Data path:
//   A command accepted on s_* is held in the input register; the sequencer
//   resolves it combinationally and the result register captures its result
//   when it can load, which raises m_tvalid. One command per cycle is
//   sustained while m_tready stays high.
// Reset:
//   arst_n clears both streams, idles the sequencer with both lines released
//   and reloads the configuration defaults.
// Stall:
//   While m_tready is low the result is held; one more command waits in the
//   input register, then s_tready drops until the receiver takes the result.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_memory_transaction_master_top (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write port
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [17:0] cfg_data,
	// command stream
	input  wire         s_tvalid,
	output logic        s_tready,
	// [15:0] mem_address, [31:16] length, [39:32] data_byte, [40] sda_in
	input  wire  [47:0] s_tdata,
	// [1:0] cmd
	input  wire  [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	// [0] scl_level, [1] sda_level, [2] need_data, [10:3] read_byte,
	// [11] read_valid, [12] busy_res, [14:13] status
	output logic [15:0] m_tdata
);
	import i2cm_pkg::*;

	cfg_wr_t cfg;
	item_t   in_item;
	item_t   item_s1;
	res_t    res;
	res_t    res_q;
	logic    go;
	logic    can_load;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// unpack the command fields
	assign in_item.cmd         = s_tuser;
	assign in_item.mem_address = s_tdata[15:0];
	assign in_item.length      = s_tdata[16 +: LEN_W];
	assign in_item.data_byte   = s_tdata[39:32];
	assign in_item.sda_in      = s_tdata[40];

	i2cm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.can_load (can_load),
		.item_s1  (item_s1),
		.go       (go)
	);

	i2cm_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.go      (go),
		.item_s1 (item_s1),
		.res     (res)
	);

	i2cm_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.res       (res),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res_q     (res_q)
	);

	// pack the result fields, lowest first, pad to whole bytes
	assign m_tdata = {1'b0, res_q.status, res_q.busy_res, res_q.read_valid,
		res_q.read_byte, res_q.need_data, res_q.sda_level, res_q.scl_level};

endmodule

`default_nettype wire
